/* hdl/key_value_table_macros.svh */
// Assertion macros shared by the key_value_table RTL.
// Depends on nothing; files that assert include it by its bare name.
`ifndef KEY_VALUE_TABLE_MACROS_SVH
`define KEY_VALUE_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define KVT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("key_value_table: assertion failed");
`define KVT_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("key_value_table: forbidden condition seen");
`else
`define KVT_ASSERT(lbl, clk, rstn, prop)
`define KVT_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* hdl/kvt_pkg.sv */
// Types shared by the key/value table cells and the top level.
// No dependencies.
`timescale 1ns / 1ps

package kvt_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_WRITE  = 2'd1,
    OP_REMOVE = 2'd2
  } kvt_op_e;

  // Update applied to one slot once a request has walked the whole row.
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_CLEAR  = 2'd3
  } kvt_cmd_e;

  // Control part of the request token that moves from cell to cell.
  typedef struct packed {
    logic    valid;
    kvt_op_e op;
    logic    match;
    logic    free;
  } kvt_tok_t;

endpackage

/* hdl/kvt_cell.sv */
// One slot of the key/value table plus one stage of the request token chain.
// Depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_cell #(
  parameter int KW  = 32,
  parameter int VW  = 64,
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kvt_pkg::kvt_tok_t tok_i,
  input  logic [KW-1:0]     key_i,
  input  logic [VW-1:0]     val_i,
  input  logic [IW-1:0]     midx_i,
  input  logic [VW-1:0]     mval_i,
  input  logic [IW-1:0]     fidx_i,
  output kvt_pkg::kvt_tok_t tok_o,
  output logic [KW-1:0]     key_o,
  output logic [VW-1:0]     val_o,
  output logic [IW-1:0]     midx_o,
  output logic [VW-1:0]     mval_o,
  output logic [IW-1:0]     fidx_o,
  input  kvt_pkg::kvt_cmd_e cmd_i,
  input  logic [IW-1:0]     cidx_i,
  input  logic [KW-1:0]     ckey_i,
  input  logic [VW-1:0]     cval_i
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic              slot_valid_q, slot_valid_d;
  logic [KW-1:0]     slot_key_q, slot_key_d;
  logic [VW-1:0]     slot_value_q, slot_value_d;
  kvt_pkg::kvt_tok_t tok_q, tok_d;
  logic [KW-1:0]     tok_key_q;
  logic [VW-1:0]     tok_val_q;
  logic [IW-1:0]     tok_midx_q, tok_midx_d;
  logic [VW-1:0]     tok_mval_q, tok_mval_d;
  logic [IW-1:0]     tok_fidx_q, tok_fidx_d;
  logic              hit_here, free_here;

  always_comb begin
    hit_here  = tok_i.valid && slot_valid_q && (slot_key_q == key_i);
    free_here = tok_i.valid && !slot_valid_q;

    tok_d       = tok_i;
    tok_d.match = tok_i.match | hit_here;
    tok_d.free  = tok_i.free | free_here;
    tok_midx_d  = hit_here ? MyIdx : midx_i;
    tok_mval_d  = hit_here ? slot_value_q : mval_i;
    // Only the first free slot along the row is remembered.
    tok_fidx_d  = (free_here && !tok_i.free) ? MyIdx : fidx_i;

    slot_valid_d = slot_valid_q;
    slot_key_d   = slot_key_q;
    slot_value_d = slot_value_q;
    if (cidx_i == MyIdx) begin
      unique case (cmd_i)
        kvt_pkg::CMD_INSERT: begin
          slot_valid_d = 1'b1;
          slot_key_d   = ckey_i;
          slot_value_d = cval_i;
        end
        kvt_pkg::CMD_UPDATE: begin
          slot_value_d = cval_i;
        end
        kvt_pkg::CMD_CLEAR: begin
          slot_valid_d = 1'b0;
        end
        kvt_pkg::CMD_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
      tok_q        <= '0;
    end else begin
      slot_valid_q <= slot_valid_d;
      tok_q        <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_key_q   <= slot_key_d;
    slot_value_q <= slot_value_d;
    tok_key_q    <= key_i;
    tok_val_q    <= val_i;
    tok_midx_q   <= tok_midx_d;
    tok_mval_q   <= tok_mval_d;
    tok_fidx_q   <= tok_fidx_d;
  end

  assign tok_o  = tok_q;
  assign key_o  = tok_key_q;
  assign val_o  = tok_val_q;
  assign midx_o = tok_midx_q;
  assign mval_o = tok_mval_q;
  assign fidx_o = tok_fidx_q;

endmodule

/* hdl/key_value_table.sv */
// Top level of the key/value table: a row of slot cells, commit logic and
// the output register with its skid slot. Depends on kvt_pkg, kvt_cell and
// key_value_table_macros.svh.
`timescale 1ns / 1ps

// The table holds up to ENTRIES unique keys, one per cell in a row. An
// accepted request travels down the row one cell per clock, collecting the
// matching slot and the lowest free slot, and when it leaves the last cell
// the table is updated and the result is loaded into the output register,
// or into the skid slot while the output register still holds a result.
// No new request is taken until the previous one has left the row. A new
// request is taken even while the previous result still waits at the
// output; only a second waiting result stalls the input.
// Slot valid bits are cleared by reset, so no clearing pass is needed.
// Request transactions carry the operation code in s_axis_tuser; op 3
// changes nothing and returns an all-zero result. The miss value register
// is written through cfg_we_i / cfg_wdata_i; the user must write it only
// while the table is idle, and the block has no check for this.

`include "key_value_table_macros.svh"

module key_value_table #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [63:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // key [31:0], new_value [95:32]
  input  logic [1:0]   s_axis_tuser,   // op [1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata    // read_value [63:0], hit [64],
                                       // full_drop [65], zero [71:66]
);

  localparam int KW      = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VW      = VALUE_BITS;
  localparam int IW      = $clog2(ENTRIES);
  localparam int ResW    = 66;
  localparam int KeyOffs = 32;

  kvt_pkg::kvt_tok_t tok   [ENTRIES+1];
  logic [KW-1:0]     tkey  [ENTRIES+1];
  logic [VW-1:0]     tval  [ENTRIES+1];
  logic [IW-1:0]     tmidx [ENTRIES+1];
  logic [VW-1:0]     tmval [ENTRIES+1];
  logic [IW-1:0]     tfidx [ENTRIES+1];
  logic [ENTRIES-1:0] tok_v;

  kvt_pkg::kvt_tok_t tok_in;
  kvt_pkg::kvt_cmd_e cmd;
  logic [IW-1:0]     cidx;
  kvt_pkg::kvt_tok_t last;
  logic              s_accept;
  logic              out_free;
  logic [63:0]       res_rd;
  logic              res_hit, res_drop;
  logic [ResW-1:0]   res;

  logic [63:0]     miss_q;
  logic            busy_q, busy_d;
  logic            out_valid_q, out_valid_d;
  logic [ResW-1:0] out_data_q, out_data_d;
  logic            pend_valid_q, pend_valid_d;
  logic [ResW-1:0] pend_data_q, pend_data_d;

  assign s_axis_tready = !busy_q && !pend_valid_q;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    tok_in       = '0;
    tok_in.valid = s_accept;
    tok_in.op    = kvt_pkg::kvt_op_e'(s_axis_tuser);
  end
  assign tok[0]   = tok_in;
  assign tkey[0]  = s_axis_tdata[KW-1:0];
  assign tval[0]  = s_axis_tdata[KeyOffs +: VW];
  assign tmidx[0] = '0;
  assign tmval[0] = '0;
  assign tfidx[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvt_cell #(
      .KW  (KW),
      .VW  (VW),
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[i]),
      .key_i  (tkey[i]),
      .val_i  (tval[i]),
      .midx_i (tmidx[i]),
      .mval_i (tmval[i]),
      .fidx_i (tfidx[i]),
      .tok_o  (tok[i+1]),
      .key_o  (tkey[i+1]),
      .val_o  (tval[i+1]),
      .midx_o (tmidx[i+1]),
      .mval_o (tmval[i+1]),
      .fidx_o (tfidx[i+1]),
      .cmd_i  (cmd),
      .cidx_i (cidx),
      .ckey_i (tkey[ENTRIES]),
      .cval_i (tval[ENTRIES])
    );
    assign tok_v[i] = tok[i+1].valid;
  end

  assign last = tok[ENTRIES];

  // Decide the result and the slot update once the token leaves the row.
  always_comb begin
    res_rd   = '0;
    res_hit  = 1'b0;
    res_drop = 1'b0;
    cmd      = kvt_pkg::CMD_NONE;
    cidx     = tmidx[ENTRIES];
    if (last.valid) begin
      unique case (last.op)
        kvt_pkg::OP_LOOKUP: begin
          res_hit = last.match;
          res_rd  = last.match ? 64'(tmval[ENTRIES]) : miss_q;
        end
        kvt_pkg::OP_WRITE: begin
          priority if (last.match) begin
            cmd     = kvt_pkg::CMD_UPDATE;
            res_hit = 1'b1;
          end else if (last.free) begin
            cmd  = kvt_pkg::CMD_INSERT;
            cidx = tfidx[ENTRIES];
          end else begin
            res_drop = 1'b1;
          end
        end
        kvt_pkg::OP_REMOVE: begin
          if (last.match) begin
            cmd     = kvt_pkg::CMD_CLEAR;
            res_hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    res = {res_drop, res_hit, res_rd};
  end

  always_comb begin
    out_free     = !out_valid_q || m_axis_tready;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    pend_valid_d = pend_valid_q;
    pend_data_d  = pend_data_q;
    busy_d       = busy_q;

    priority if (s_accept) begin
      busy_d = 1'b1;
    end else if (last.valid) begin
      busy_d = 1'b0;
    end else begin
      busy_d = busy_q;
    end

    priority if (last.valid) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_data_d  = res;
      end else begin
        pend_valid_d = 1'b1;
        pend_data_d  = res;
      end
    end else if (out_free) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = pend_data_q;
        pend_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q       <= '0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        miss_q <= cfg_wdata_i;
      end
      busy_q       <= busy_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    pend_data_q <= pend_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(72 - ResW){1'b0}}, out_data_q};

  // Only one request is ever in flight along the row.
  `KVT_ASSERT(a_single_token, clk_i, rst_ni, $onehot0(tok_v))
  `KVT_ASSERT(a_idle_row_empty, clk_i, rst_ni, !busy_q |-> (tok_v == '0))
  `KVT_ASSERT(a_accept_busy, clk_i, rst_ni, s_accept |=> busy_q)
  `KVT_ASSERT(a_pend_behind_out, clk_i, rst_ni, pend_valid_q |-> out_valid_q)
  `KVT_ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, s_accept && last.valid)

endmodule

/* tb/testbench.sv */
// Self-checking testbench for key_value_table: a queue-fed stream driver, a
// result monitor and a behavioral table model that predicts every result.
// Depends on kvt_pkg and the key_value_table RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int ENTRIES = 16;
  localparam int LATENCY = ENTRIES + 1;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int POOL_MAX = 32;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [63:0] value;
  } kv_req_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic        hit;
    logic        full_drop;
  } kv_resp_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [63:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;   // key [31:0], new_value [95:32]
  logic [1:0]   s_axis_tuser = '0;   // op [1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;        // read_value [63:0], hit [64], full_drop [65]

  key_value_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the table and its miss value.
  logic        slot_used [ENTRIES];
  logic [31:0] slot_key  [ENTRIES];
  logic [63:0] slot_data [ENTRIES];
  logic [63:0] miss_mv = '0;

  kv_req_t  req_q [$];
  kv_resp_t want_q [$];
  kv_req_t  cur_req;
  logic [31:0] key_pool [POOL_MAX];

  int  err_cnt = 0;
  int  sent_cnt = 0;
  int  src_gap = 0;
  int  sink_gap = 0;
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;
  bit  calm = 1'b0;

  // Applies one request to the shadow table and returns the result it gives.
  function automatic kv_resp_t table_apply(kv_req_t r);
    kv_resp_t res;
    int m;
    int f;
    res = '0;
    m = -1;
    f = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == r.key) m = i;
      if (!slot_used[i]) f = i;
    end
    if (r.op == kvt_pkg::OP_LOOKUP) begin
      if (m >= 0) begin
        res.read_value = slot_data[m];
        res.hit = 1'b1;
      end else begin
        res.read_value = miss_mv;
      end
    end else if (r.op == kvt_pkg::OP_WRITE) begin
      if (m >= 0) begin
        slot_data[m] = r.value;
        res.hit = 1'b1;
      end else if (f >= 0) begin
        slot_used[f] = 1'b1;
        slot_key[f] = r.key;
        slot_data[f] = r.value;
      end else begin
        res.full_drop = 1'b1;
      end
    end else if (r.op == kvt_pkg::OP_REMOVE) begin
      if (m >= 0) begin
        slot_used[m] = 1'b0;
        res.hit = 1'b1;
      end
    end
    return res;
  endfunction

  // Request driver: records each accepted transaction, then offers the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        want_q.insert(want_q.size(), table_apply(cur_req));
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          src_gap <= $urandom_range(0, 13);
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          s_axis_tdata <= {cur_req.value, cur_req.key};
          s_axis_tuser <= cur_req.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off, so the table backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && sent_cnt >= HOLD_AT) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    kv_resp_t want;
    kv_resp_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.read_value = m_axis_tdata[63:0];
        got.hit = m_axis_tdata[64];
        got.full_drop = m_axis_tdata[65];
        if (want_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected result rd=%h hit=%b drop=%b", $realtime,
                     got.read_value, got.hit, got.full_drop);
        end else begin
          want = want_q.pop_front();
          if (got.read_value !== want.read_value || got.hit !== want.hit ||
              got.full_drop !== want.full_drop) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch rd=%h/%h hit=%b/%b drop=%b/%b (expected/actual)",
                       $realtime, want.read_value, got.read_value, want.hit, got.hit,
                       want.full_drop, got.full_drop);
          end
        end
      end
      if (hold_cnt > 0) begin
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_gap <= $urandom_range(0, 13);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic queue_req(logic [1:0] op, logic [31:0] key, logic [63:0] value);
    kv_req_t r;
    r.op = op;
    r.key = key;
    r.value = value;
    req_q.insert(req_q.size(), r);
  endtask

  // Returns at a falling edge once every request has been sent and answered.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_q.size() != 0 || s_axis_tvalid || want_q.size() != 0);
  endtask

  task automatic set_miss_value(logic [63:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    miss_mv = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random traffic over a small key pool, so that hits, updates, removals
  // and a full table all come up; a few keys are drawn at random as noise.
  task automatic queue_random(int n, int pool_n, int rm_pct);
    int r;
    logic [1:0]  op;
    logic [31:0] key;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_MAX; i++) key_pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) op = OP_UNUSED;
      else if (r < 4 + rm_pct) op = kvt_pkg::OP_REMOVE;
      else if (r < 4 + rm_pct + (96 - rm_pct) / 2) op = kvt_pkg::OP_WRITE;
      else op = kvt_pkg::OP_LOOKUP;
      if ($urandom_range(0, 9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, pool_n - 1)];
      queue_req(op, key, {$urandom, $urandom});
    end
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: miss on an empty table, extreme keys and values,
    // update in place, removal of an absent key, the unused op code,
    // then filling the table until a new key is dropped.
    queue_req(kvt_pkg::OP_LOOKUP, 32'd5, '1);
    queue_req(kvt_pkg::OP_WRITE, '0, '0);
    queue_req(kvt_pkg::OP_WRITE, '1, '1);
    queue_req(kvt_pkg::OP_LOOKUP, '0, '1);
    queue_req(kvt_pkg::OP_LOOKUP, '1, '0);
    queue_req(kvt_pkg::OP_WRITE, '0, 64'h0123_4567_89ab_cdef);
    queue_req(kvt_pkg::OP_LOOKUP, '0, '0);
    queue_req(kvt_pkg::OP_REMOVE, 32'h0001_2345, '0);
    queue_req(kvt_pkg::OP_REMOVE, '1, '0);
    queue_req(kvt_pkg::OP_LOOKUP, '1, '0);
    queue_req(OP_UNUSED, '1, '1);
    for (int i = 1; i < ENTRIES; i++)
      queue_req(kvt_pkg::OP_WRITE, 32'h1000_0000 + i, {$urandom, $urandom});
    queue_req(kvt_pkg::OP_WRITE, 32'hdead_beef, '1);
    queue_req(kvt_pkg::OP_WRITE, '0, '1);
    wait_drained();

    set_miss_value('1);
    queue_random(310, 24, 30);
    wait_drained();

    set_miss_value({$urandom, $urandom});
    queue_random(310, 12, 20);
    wait_drained();

    set_miss_value('0);
    queue_random(310, 32, 15);
    wait_drained();

    set_miss_value({$urandom, $urandom});
    queue_random(310, 20, 35);
    wait_drained();

    // Last phase runs with both sides streaming freely.
    calm = 1'b1;
    set_miss_value(64'h8000_0000_0000_0001);
    queue_random(310, 18, 25);
    wait_drained();

    repeat (3 * LATENCY) @(posedge clk_i);
    if (err_cnt == 0 && want_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/kvt_pkg.sv
hdl/kvt_cell.sv
hdl/key_value_table.sv
tb/testbench.sv
